@@ design/woc_pkg.sv @@
// Shared types and constants for the window overlay compositor.
// Depends on nothing; every other design file refers to it by scoped names.
package woc_pkg;

  localparam int COORD_BITS   = 12;
  localparam int CHAR_BITS    = 8;
  localparam int SLOT_BITS    = 7;
  localparam int COUNT_BITS   = 8;
  localparam int CFG_IDX_BITS = 3;
  // Wide enough for any table index up to the largest supported table.
  localparam int IDX_BITS     = 11;
  // Windows checked by one pipeline stage.
  localparam int GROUP_SIZE   = 16;

  localparam logic [CHAR_BITS-1:0]  BLANK_CHAR       = 8'd32;
  localparam logic [COORD_BITS-1:0] DISP_X_HIGH_INIT = 12'd79;
  localparam logic [COORD_BITS-1:0] DISP_Y_HIGH_INIT = 12'd23;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CHAR_BITS-1:0]  char_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DISP_X_LOW  = 3'd0,
    CFG_DISP_Y_LOW  = 3'd1,
    CFG_DISP_X_HIGH = 3'd2,
    CFG_DISP_Y_HIGH = 3'd3,
    CFG_WIN_COUNT   = 3'd4
  } cfg_reg_t;

  // Input item.
  typedef struct packed {
    opcode_t                opcode;
    logic [SLOT_BITS-1:0]   slot;
    coord_t                 win_x_low;
    coord_t                 win_y_low;
    coord_t                 win_x_high;
    coord_t                 win_y_high;
    char_t                  fill_char;
    coord_t                 pixel_x;
    coord_t                 pixel_y;
  } req_t;

  // Result item.
  typedef struct packed {
    char_t pixel_char;
    logic  in_display;
  } rsp_t;

  // Display rectangle as held in the configuration registers.
  typedef struct packed {
    coord_t x_low;
    coord_t y_low;
    coord_t x_high;
    coord_t y_high;
  } disp_t;

  // Item as it travels down the pipeline.
  typedef struct packed {
    opcode_t              opcode;
    logic [SLOT_BITS-1:0] slot;
    coord_t               win_x_low;
    coord_t               win_y_low;
    coord_t               win_x_high;
    coord_t               win_y_high;
    char_t                fill_char;
    coord_t               pixel_x;
    coord_t               pixel_y;
    logic                 in_display;
    char_t                pixel_char;
  } stage_t;

endpackage

@@ design/woc_ingress.sv @@
// First pipeline stage: registers the input item and checks the pixel against the display.
// Depends on woc_pkg.
module woc_ingress (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           req_valid,
  input  woc_pkg::req_t  req,
  input  woc_pkg::disp_t disp,
  output logic           st_valid,
  output woc_pkg::stage_t st
);

  woc_pkg::stage_t st_next;

  // Display bounds check and initial blank character.
  always_comb begin
    st_next.opcode     = req.opcode;
    st_next.slot       = req.slot;
    st_next.win_x_low  = req.win_x_low;
    st_next.win_y_low  = req.win_y_low;
    st_next.win_x_high = req.win_x_high;
    st_next.win_y_high = req.win_y_high;
    st_next.fill_char  = req.fill_char;
    st_next.pixel_x    = req.pixel_x;
    st_next.pixel_y    = req.pixel_y;
    st_next.in_display = (req.pixel_x >= disp.x_low) && (req.pixel_x <= disp.x_high) &&
                         (req.pixel_y >= disp.y_low) && (req.pixel_y <= disp.y_high);
    st_next.pixel_char = woc_pkg::BLANK_CHAR;
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (advance) begin
      st_valid <= req_valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (advance && req_valid) begin
      st <= st_next;
    end
  end

endmodule

@@ design/woc_group.sv @@
// One pipeline stage holding a group of window table entries and their coverage test.
// Depends on woc_pkg.
module woc_group #(
  parameter int BASE  = 0,
  parameter int CELLS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic [woc_pkg::COUNT_BITS-1:0]     count,
  input  logic                               in_valid,
  input  woc_pkg::stage_t                    in_st,
  output logic                               out_valid,
  output woc_pkg::stage_t                    out_st
);

  woc_pkg::coord_t cell_xl [CELLS];
  woc_pkg::coord_t cell_yl [CELLS];
  woc_pkg::coord_t cell_xh [CELLS];
  woc_pkg::coord_t cell_yh [CELLS];
  woc_pkg::char_t  cell_ch [CELLS];

  logic [CELLS-1:0]        write_en;
  logic [CELLS-1:0]        hit;
  logic                    any_hit;
  woc_pkg::char_t          group_char;
  woc_pkg::stage_t         out_st_next;
  logic [woc_pkg::IDX_BITS-1:0] slot_ext;
  logic [woc_pkg::IDX_BITS-1:0] count_ext;

  assign slot_ext  = woc_pkg::IDX_BITS'(in_st.slot);
  assign count_ext = woc_pkg::IDX_BITS'(count);

  // Slot decode for loads and coverage test for queries, one per entry.
  always_comb begin
    for (int j = 0; j < CELLS; j++) begin
      write_en[j] = advance && in_valid && (in_st.opcode == woc_pkg::OP_LOAD) &&
                    (slot_ext == woc_pkg::IDX_BITS'(BASE + j));
      hit[j] = in_valid && (in_st.opcode == woc_pkg::OP_QUERY) && in_st.in_display &&
               (count_ext > woc_pkg::IDX_BITS'(BASE + j)) &&
               (in_st.pixel_x >= cell_xl[j]) && (in_st.pixel_x <= cell_xh[j]) &&
               (in_st.pixel_y >= cell_yl[j]) && (in_st.pixel_y <= cell_yh[j]);
    end
  end

  // The highest covering entry of this group wins, and paints over earlier groups.
  always_comb begin
    any_hit    = 1'b0;
    group_char = woc_pkg::BLANK_CHAR;
    for (int j = 0; j < CELLS; j++) begin
      if (hit[j]) begin
        any_hit    = 1'b1;
        group_char = cell_ch[j];
      end
    end
    out_st_next = in_st;
    if (any_hit) begin
      out_st_next.pixel_char = group_char;
    end
  end

  // Table entries are written when the load passes through this stage.
  always_ff @(posedge clk) begin
    for (int j = 0; j < CELLS; j++) begin
      if (write_en[j]) begin
        cell_xl[j] <= in_st.win_x_low;
        cell_yl[j] <= in_st.win_y_low;
        cell_xh[j] <= in_st.win_x_high;
        cell_yh[j] <= in_st.win_y_high;
        cell_ch[j] <= in_st.fill_char;
      end
    end
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_st <= out_st_next;
    end
  end

endmodule

@@ design/window_overlay_compositor_top.sv @@
// Throughput: one item per cycle unless a result waits at the output.
// Each stage tests 16 table entries, so the pipeline depth follows the table size.
// Loads travel down the pipeline and write their entry in the stage that owns the slot.
// Synchronous reset clears the valid bits and the count register and sets the display to its initial bounds.
// The window table is not cleared by reset and holds garbage until loaded.
module window_overlay_compositor_top #(
  parameter int MAX_WINDOWS = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  woc_pkg::req_t                     req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output woc_pkg::rsp_t                     rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [woc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [woc_pkg::COORD_BITS-1:0]    cfg_data
);

  localparam int NUM_GROUPS = (MAX_WINDOWS + woc_pkg::GROUP_SIZE - 1) / woc_pkg::GROUP_SIZE;

  woc_pkg::disp_t                    disp;
  logic [woc_pkg::COUNT_BITS-1:0]    window_count;
  logic                              advance;
  logic                              pipe_valid [NUM_GROUPS+1];
  woc_pkg::stage_t                   pipe_st    [NUM_GROUPS+1];

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp.x_low   <= '0;
      disp.y_low   <= '0;
      disp.x_high  <= woc_pkg::DISP_X_HIGH_INIT;
      disp.y_high  <= woc_pkg::DISP_Y_HIGH_INIT;
      window_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        woc_pkg::CFG_DISP_X_LOW:  disp.x_low   <= cfg_data;
        woc_pkg::CFG_DISP_Y_LOW:  disp.y_low   <= cfg_data;
        woc_pkg::CFG_DISP_X_HIGH: disp.x_high  <= cfg_data;
        woc_pkg::CFG_DISP_Y_HIGH: disp.y_high  <= cfg_data;
        woc_pkg::CFG_WIN_COUNT:   window_count <= cfg_data[woc_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a result waits at the output.
  assign advance   = !(rsp_valid && !rsp_ready);
  assign req_ready = advance;

  // Display check stage.
  woc_ingress u_ingress (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req),
    .disp      (disp),
    .st_valid  (pipe_valid[0]),
    .st        (pipe_st[0])
  );

  // One stage per group of table entries, lowest slots first.
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    localparam int BASE  = g * woc_pkg::GROUP_SIZE;
    localparam int CELLS = (MAX_WINDOWS - BASE < woc_pkg::GROUP_SIZE) ?
                           (MAX_WINDOWS - BASE) : woc_pkg::GROUP_SIZE;
    woc_group #(
      .BASE  (BASE),
      .CELLS (CELLS)
    ) u_group (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .count     (window_count),
      .in_valid  (pipe_valid[g]),
      .in_st     (pipe_st[g]),
      .out_valid (pipe_valid[g+1]),
      .out_st    (pipe_st[g+1])
    );
  end

  // Only queries leave a result; loads drop out at the last stage.
  assign rsp_valid       = pipe_valid[NUM_GROUPS] &&
                           (pipe_st[NUM_GROUPS].opcode == woc_pkg::OP_QUERY);
  assign rsp.pixel_char  = pipe_st[NUM_GROUPS].pixel_char;
  assign rsp.in_display  = pipe_st[NUM_GROUPS].in_display;

  // A pixel outside the display always shows a blank.
  a_outside_blank: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.in_display |-> rsp.pixel_char == woc_pkg::BLANK_CHAR)
    else $error("pixel outside the display did not return a blank");

  // Input stalls only when a result is held back at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("input stalled without output backpressure");

  // No result is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result presented right after reset");

  // A stalled first stage keeps its item.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !advance && pipe_valid[0] |=> pipe_valid[0])
    else $error("first stage lost its item during a stall");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for window_overlay_compositor_top: directed and random pixel queries and window loads.
// Uses woc_pkg types; predicts each pixel with its own copy of the window table and display.
module tb_top;

  localparam int MAX_WINDOWS     = 128;
  localparam int COORD_MAX       = (1 << woc_pkg::COORD_BITS) - 1;
  localparam int PIPE_DEPTH      = 1 + (MAX_WINDOWS + woc_pkg::GROUP_SIZE - 1) /
                                   woc_pkg::GROUP_SIZE;
  localparam int SETTLE_CYCLES   = 2 * PIPE_DEPTH + 4;
  localparam int SCENE_COUNT     = 10;
  localparam int ITEMS_PER_SCENE = 75;

  typedef struct packed {
    woc_pkg::coord_t x_low;
    woc_pkg::coord_t y_low;
    woc_pkg::coord_t x_high;
    woc_pkg::coord_t y_high;
    woc_pkg::char_t  paint;
  } window_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  woc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  woc_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [woc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [woc_pkg::COORD_BITS-1:0] cfg_data = '0;

  // Predictor state: window table, display rectangle and active window count.
  window_t window_store [MAX_WINDOWS];
  woc_pkg::disp_t screen;
  logic [woc_pkg::COUNT_BITS-1:0] active_count;

  woc_pkg::rsp_t expected_pixels [$];
  int mismatch_count = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  window_overlay_compositor_top #(
    .MAX_WINDOWS(MAX_WINDOWS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Gap length for either side: mostly none, some short, a few long.
  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Applies one accepted item to the predictor; returns 1 when the item yields a pixel.
  function automatic bit model_item(input woc_pkg::req_t item, output woc_pkg::rsp_t pixel);
    int n;
    bit on_screen;
    woc_pkg::char_t ch;
    pixel = '0;
    if (item.opcode == woc_pkg::OP_LOAD) begin
      window_store[item.slot] = '{item.win_x_low, item.win_y_low, item.win_x_high,
                                  item.win_y_high, item.fill_char};
      return 1'b0;
    end
    on_screen = item.pixel_x >= screen.x_low && item.pixel_x <= screen.x_high &&
                item.pixel_y >= screen.y_low && item.pixel_y <= screen.y_high;
    ch = woc_pkg::BLANK_CHAR;
    if (on_screen) begin
      n = (active_count > MAX_WINDOWS) ? MAX_WINDOWS : active_count;
      // Later windows paint over earlier ones.
      for (int i = 0; i < n; i++) begin
        if (item.pixel_x >= window_store[i].x_low && item.pixel_x <= window_store[i].x_high &&
            item.pixel_y >= window_store[i].y_low && item.pixel_y <= window_store[i].y_high) begin
          ch = window_store[i].paint;
        end
      end
    end
    pixel.pixel_char = ch;
    pixel.in_display = on_screen;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Drives one item and holds it until its transfer, then maybe idles.
  task automatic send_item(input woc_pkg::req_t item);
    woc_pkg::rsp_t pixel;
    int gap;
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    if (model_item(item, pixel)) expected_pixels.push_back(pixel);
    gap = idle_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits for every expected pixel, then for loads still in the pipeline.
  task automatic wait_pipeline_empty();
    req_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(woc_pkg::cfg_reg_t idx,
                                logic [woc_pkg::COORD_BITS-1:0] word);
    cfg_index <= idx;
    cfg_data <= word;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      woc_pkg::CFG_DISP_X_LOW:  screen.x_low = word;
      woc_pkg::CFG_DISP_Y_LOW:  screen.y_low = word;
      woc_pkg::CFG_DISP_X_HIGH: screen.x_high = word;
      woc_pkg::CFG_DISP_Y_HIGH: screen.y_high = word;
      woc_pkg::CFG_WIN_COUNT:   active_count = word[woc_pkg::COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Writes every register once the block has gone idle.
  task automatic apply_settings(woc_pkg::disp_t d,
                                logic [woc_pkg::COORD_BITS-1:0] count_word);
    wait_pipeline_empty();
    write_register(woc_pkg::CFG_DISP_X_LOW, d.x_low);
    write_register(woc_pkg::CFG_DISP_Y_LOW, d.y_low);
    write_register(woc_pkg::CFG_DISP_X_HIGH, d.x_high);
    write_register(woc_pkg::CFG_DISP_Y_HIGH, d.y_high);
    write_register(woc_pkg::CFG_WIN_COUNT, count_word);
    cfg_valid <= 1'b0;
  endtask

  // Random bits in every field, so fields that the opcode ignores also toggle.
  function automatic woc_pkg::req_t random_payload();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(woc_pkg::req_t)-1:0];
  endfunction

  function automatic woc_pkg::req_t load_item(logic [woc_pkg::SLOT_BITS-1:0] slot,
                                              woc_pkg::coord_t xl, woc_pkg::coord_t yl,
                                              woc_pkg::coord_t xh, woc_pkg::coord_t yh,
                                              woc_pkg::char_t paint);
    woc_pkg::req_t item;
    item = random_payload();
    item.opcode = woc_pkg::OP_LOAD;
    item.slot = slot;
    item.win_x_low = xl;
    item.win_y_low = yl;
    item.win_x_high = xh;
    item.win_y_high = yh;
    item.fill_char = paint;
    return item;
  endfunction

  function automatic woc_pkg::req_t query_item(woc_pkg::coord_t x, woc_pkg::coord_t y);
    woc_pkg::req_t item;
    item = random_payload();
    item.opcode = woc_pkg::OP_QUERY;
    item.pixel_x = x;
    item.pixel_y = y;
    return item;
  endfunction

  function automatic woc_pkg::coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return woc_pkg::coord_t'(COORD_MAX);
    return woc_pkg::coord_t'(v);
  endfunction

  // A coordinate in or just around the span between two bounds.
  function automatic woc_pkg::coord_t near_span(woc_pkg::coord_t lo, woc_pkg::coord_t hi);
    int a, b;
    a = (lo <= hi) ? int'(lo) : int'(hi);
    b = (lo <= hi) ? int'(hi) : int'(lo);
    return clamp_coord(a - 4 + int'($urandom_range(0, b - a + 8)));
  endfunction

  function automatic woc_pkg::coord_t edge_coord(woc_pkg::coord_t lo, woc_pkg::coord_t hi);
    case ($urandom_range(0, 3))
      0: return clamp_coord(int'(lo) - 1);
      1: return lo;
      2: return hi;
      default: return clamp_coord(int'(hi) + 1);
    endcase
  endfunction

  // Window placed around the current display, sometimes inverted or fully random.
  function automatic woc_pkg::req_t random_load(logic [woc_pkg::SLOT_BITS-1:0] slot);
    woc_pkg::req_t item;
    int r, span_x, span_y;
    woc_pkg::coord_t t;
    item = random_payload();
    item.opcode = woc_pkg::OP_LOAD;
    item.slot = slot;
    r = $urandom_range(0, 99);
    if (r >= 20) begin
      span_x = (screen.x_high >= screen.x_low) ? int'(screen.x_high) - int'(screen.x_low) : 20;
      span_y = (screen.y_high >= screen.y_low) ? int'(screen.y_high) - int'(screen.y_low) : 20;
      item.win_x_low = near_span(screen.x_low, screen.x_high);
      item.win_y_low = near_span(screen.y_low, screen.y_high);
      item.win_x_high = clamp_coord(int'(item.win_x_low) +
                                    int'($urandom_range(0, span_x / 2 + 3)));
      item.win_y_high = clamp_coord(int'(item.win_y_low) +
                                    int'($urandom_range(0, span_y / 2 + 3)));
      if (r < 30) begin
        t = item.win_x_low;
        item.win_x_low = item.win_x_high;
        item.win_x_high = t;
      end
    end
    return item;
  endfunction

  function automatic woc_pkg::req_t random_query();
    woc_pkg::req_t item;
    int r;
    item = random_payload();
    item.opcode = woc_pkg::OP_QUERY;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      item.pixel_x = near_span(screen.x_low, screen.x_high);
      item.pixel_y = near_span(screen.y_low, screen.y_high);
    end else if (r < 85) begin
      item.pixel_x = edge_coord(screen.x_low, screen.x_high);
      item.pixel_y = edge_coord(screen.y_low, screen.y_high);
    end
    return item;
  endfunction

  // Loads go mostly to active slots so that they change what queries see.
  function automatic logic [woc_pkg::SLOT_BITS-1:0] random_slot();
    int live;
    live = (active_count > MAX_WINDOWS) ? MAX_WINDOWS : active_count;
    if (live != 0 && $urandom_range(0, 99) < 70) begin
      return woc_pkg::SLOT_BITS'($urandom_range(0, live - 1));
    end
    return woc_pkg::SLOT_BITS'($urandom_range(0, MAX_WINDOWS - 1));
  endfunction

  function automatic woc_pkg::disp_t pick_display(int scene);
    woc_pkg::disp_t d;
    case (scene)
      0: d = '{x_low: 0, y_low: 0, x_high: woc_pkg::coord_t'(COORD_MAX),
               y_high: woc_pkg::coord_t'(COORD_MAX)};
      1: d = '{x_low: woc_pkg::coord_t'(COORD_MAX - 7), y_low: woc_pkg::coord_t'(COORD_MAX - 7),
               x_high: woc_pkg::coord_t'(COORD_MAX), y_high: woc_pkg::coord_t'(COORD_MAX)};
      // Inverted columns: nothing lies inside.
      2: d = '{x_low: 300, y_low: 0, x_high: 200, y_high: 50};
      3: d = '{x_low: 0, y_low: 0, x_high: 0, y_high: 0};
      default: begin
        d.x_low = woc_pkg::coord_t'($urandom_range(0, COORD_MAX));
        d.y_low = woc_pkg::coord_t'($urandom_range(0, COORD_MAX));
        d.x_high = clamp_coord(int'(d.x_low) + int'($urandom_range(0, 120)));
        d.y_high = clamp_coord(int'(d.y_low) + int'($urandom_range(0, 60)));
      end
    endcase
    return d;
  endfunction

  function automatic logic [woc_pkg::COORD_BITS-1:0] pick_count(int scene);
    logic [3:0] junk;
    logic [7:0] c;
    case (scene)
      0: return 12'd128;
      // Above the table size; acts as the full table.
      1: return 12'h0FF;
      // Upper data bits lie outside the count register.
      2: return 12'hF80;
      3: return 12'd1;
      4: return 12'd0;
      default: begin
        junk = 4'($urandom);
        if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(129, 255));
        else c = 8'($urandom_range(0, MAX_WINDOWS));
        return {junk, c};
      end
    endcase
  endfunction

  // Reset display and no active windows: only the display bounds matter.
  task automatic test_display_bounds();
    send_item(query_item(12'd0, 12'd0));
    send_item(query_item(12'd79, 12'd23));
    send_item(query_item(12'd80, 12'd23));
    send_item(query_item(12'd79, 12'd24));
    send_item(query_item(12'd4095, 12'd4095));
    send_item(query_item(12'd40, 12'd12));
  endtask

  // Overlapping windows: the highest active slot wins, inverted windows cover nothing.
  task automatic test_window_priority();
    send_item(load_item(7'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 8'h41));
    send_item(load_item(7'd1, 12'd50, 12'd0, 12'd40, 12'd23, 8'h42));
    send_item(load_item(7'd2, 12'd10, 12'd5, 12'd20, 12'd10, 8'hFF));
    send_item(load_item(7'd3, 12'd15, 12'd8, 12'd15, 12'd8, 8'h00));
    send_item(load_item(7'd127, 12'd0, 12'd0, 12'd4095, 12'd4095, 8'h5A));
    apply_settings('{x_low: 0, y_low: 0, x_high: 79, y_high: 23}, 12'd4);
    send_item(query_item(12'd15, 12'd8));
    send_item(query_item(12'd12, 12'd6));
    send_item(query_item(12'd30, 12'd3));
    send_item(query_item(12'd45, 12'd10));
    send_item(query_item(12'd80, 12'd0));
    send_item(query_item(12'd0, 12'd0));
  endtask

  // Display moved to the far corner, inverted, then widened to the whole range.
  task automatic test_display_moves();
    apply_settings('{x_low: 4095, y_low: 4095, x_high: 4095, y_high: 4095}, 12'd4);
    send_item(query_item(12'd4095, 12'd4095));
    send_item(query_item(12'd4094, 12'd4095));
    send_item(query_item(12'd4095, 12'd0));
    apply_settings('{x_low: 100, y_low: 0, x_high: 50, y_high: 23}, 12'd4);
    send_item(query_item(12'd75, 12'd10));
    send_item(query_item(12'd100, 12'd10));
    apply_settings('{x_low: 0, y_low: 0, x_high: 4095, y_high: 4095}, 12'd4);
    send_item(query_item(12'd4095, 12'd0));
    send_item(query_item(12'd15, 12'd8));
  endtask

  // Random scenes; the first one loads every slot so any count reads loaded entries only.
  task automatic test_random_scenes();
    for (int scene = 0; scene < SCENE_COUNT; scene++) begin
      idle_on = (scene % 3 != 2);
      apply_settings(pick_display(scene), pick_count(scene));
      if (scene == 0) begin
        for (int s = 0; s < MAX_WINDOWS; s++) send_item(random_load(woc_pkg::SLOT_BITS'(s)));
      end
      for (int i = 0; i < ITEMS_PER_SCENE; i++) begin
        if ($urandom_range(0, 99) < 25) send_item(random_load(random_slot()));
        else send_item(random_query());
      end
    end
  endtask

  // Result side: ready drops for random stretches.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      stall_left = idle_gap();
    end
  end

  // Each result transfer is compared with the oldest expected pixel.
  always @(posedge clk) begin : check_pixels
    woc_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result transfer with nothing expected", rsp.pixel_char, -1);
      end else begin
        want = expected_pixels.pop_front();
        if (rsp.pixel_char !== want.pixel_char)
          report_mismatch("pixel_char", rsp.pixel_char, want.pixel_char);
        if (rsp.in_display !== want.in_display)
          report_mismatch("in_display", rsp.in_display, want.in_display);
      end
    end
  end

  initial begin
    screen = '{x_low: 0, y_low: 0, x_high: woc_pkg::DISP_X_HIGH_INIT,
               y_high: woc_pkg::DISP_Y_HIGH_INIT};
    active_count = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_display_bounds();
    test_window_priority();
    test_display_moves();
    test_random_scenes();
    wait_pipeline_empty();
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
